>>> hw/rtl/fault_line_heightmap_top_assert.svh
// Assertion macros shared by the fault line heightmap RTL.
// Included by the controller and the datapath; no other dependencies.
`ifndef FAULT_LINE_HEIGHTMAP_TOP_ASSERT_SVH
`define FAULT_LINE_HEIGHTMAP_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FLH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flh assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FLH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flh assertion failed");

`endif

>>> hw/rtl/flh_pkg.sv
// Package for the fault line heightmap: command and status structs and fixed codes.
// Used by flh_ctrl, flh_datapath and fault_line_heightmap_top; no dependencies.
package flh_pkg;

  localparam logic REQ_FAULT = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_LENGTH = 1'b1;

  localparam int          CFG_W          = 9;
  localparam int          CELL_W         = 8;
  localparam logic [8:0]  CFG_GRID_RESET = 9'd50;

  typedef struct packed {
    logic clear_step;
    logic start;
    logic lookup;
    logic sweep_step;
    logic load_out;
  } flh_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic grid_empty;
    logic sweep_last;
    logic out_free;
  } flh_status_t;

endpackage

>>> hw/rtl/flh_ctrl.sv
// Controller state machine of the fault line heightmap.
// Depends on flh_pkg and the assertion macro header.
`include "fault_line_heightmap_top_assert.svh"

module flh_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  flh_pkg::flh_status_t status,
  output flh_pkg::flh_cmd_t    cmd
);
  import flh_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SWEEP  = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_LOOKUP = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          if (in_req_type == REQ_READ) begin
            state_nxt = S_LOOKUP;
          end else if (status.grid_empty) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  `FLH_ASSERT_NXT(a_sweep_to_drain, clk, rst_n,
    (state_r == S_SWEEP) && status.sweep_last, state_r == S_DRAIN)
  `FLH_ASSERT_NXT(a_drain_to_finish, clk, rst_n, state_r == S_DRAIN, state_r == S_FINISH)
  `FLH_ASSERT_NXT(a_finish_to_idle, clk, rst_n,
    (state_r == S_FINISH) && status.out_free, state_r == S_IDLE)

endmodule

>>> hw/rtl/flh_datapath.sv
// Datapath of the fault line heightmap: height memory, sweep counters, line test,
// saturating update, peak tracking and the result register. Depends on flh_pkg.
`include "fault_line_heightmap_top_assert.svh"

module flh_datapath #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_LENGTH  = 256,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [flh_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_req_type,
  input  logic signed [15:0]          in_slope_x,
  input  logic signed [15:0]          in_slope_z,
  input  logic signed [23:0]          in_line_offset,
  input  logic [flh_pkg::CELL_W-1:0]  in_cell_x,
  input  logic [flh_pkg::CELL_W-1:0]  in_cell_z,
  input  flh_pkg::flh_cmd_t           cmd,
  output flh_pkg::flh_status_t        status,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic signed [15:0]          out_cell_height,
  output logic [14:0]                 out_max_height,
  output logic signed [15:0]          out_min_height
);
  import flh_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int ZW    = $clog2(MAX_LENGTH);
  localparam int AW    = XW + ZW;
  localparam int DEPTH = 1 << AW;
  localparam int XCW   = $clog2(MAX_WIDTH + 1);
  localparam int ZCW   = $clog2(MAX_LENGTH + 1);
  localparam int PW    = (XW > ZW) ? XW : ZW;
  localparam int TW    = (PW + 19 > 25) ? PW + 19 : 25;
  localparam int EW    = HEIGHT_BITS + 16;
  localparam logic signed [HEIGHT_BITS-1:0] HMAX = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
  localparam logic signed [HEIGHT_BITS-1:0] HMIN = {1'b1, {(HEIGHT_BITS-1){1'b0}}};

  logic [CFG_W-1:0] grid_w_r;
  logic [CFG_W-1:0] grid_l_r;
  logic [XCW-1:0]   gw;
  logic [ZCW-1:0]   gl;

  logic                 is_read_r;
  logic                 in_range_r;
  logic signed [15:0]   a_r;
  logic signed [15:0]   b_r;
  logic [XW-1:0]        x_r;
  logic [ZW-1:0]        z_r;
  logic signed [TW-1:0] t_r;
  logic signed [TW-1:0] row_r;
  logic signed [TW-1:0] c_neg;
  logic signed [TW-1:0] row_inc;
  logic                 t_pos;
  logic                 x_end;
  logic                 z_end;

  logic [HEIGHT_BITS-1:0] mem [DEPTH];
  logic [AW-1:0]          clr_r;
  logic                   ram_we;
  logic [AW-1:0]          ram_wa;
  logic [HEIGHT_BITS-1:0] ram_wd;
  logic                   ram_re;
  logic [AW-1:0]          ram_ra;
  logic [HEIGHT_BITS-1:0] rd_data_r;

  logic                          wb_vld_r;
  logic [AW-1:0]                 wb_addr_r;
  logic                          wb_up_r;
  logic signed [HEIGHT_BITS-1:0] h_old;
  logic signed [HEIGHT_BITS-1:0] h_new;
  logic signed [HEIGHT_BITS-1:0] peak_high_r;
  logic signed [HEIGHT_BITS-1:0] peak_low_r;

  logic                          out_valid_r;
  logic signed [HEIGHT_BITS-1:0] out_cell_r;
  logic signed [HEIGHT_BITS-1:0] out_hi_r;
  logic signed [HEIGHT_BITS-1:0] out_lo_r;
  logic signed [EW-1:0]          cell_ext;
  logic signed [EW-1:0]          hi_ext;
  logic signed [EW-1:0]          lo_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= CFG_GRID_RESET;
      grid_l_r <= CFG_GRID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_w_r <= cfg_data;
        CFG_GRID_LENGTH: grid_l_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign gw = (32'(grid_w_r) > MAX_WIDTH)  ? XCW'(MAX_WIDTH)  : XCW'(grid_w_r);
  assign gl = (32'(grid_l_r) > MAX_LENGTH) ? ZCW'(MAX_LENGTH) : ZCW'(grid_l_r);

  assign c_neg   = -(TW'(in_line_offset));
  assign row_inc = row_r + TW'(a_r);
  assign t_pos   = !t_r[TW-1] && (t_r != '0);
  assign x_end   = (XCW'(x_r) == (gw - XCW'(1)));
  assign z_end   = (ZCW'(z_r) == (gl - ZCW'(1)));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      is_read_r  <= (in_req_type == REQ_READ);
      in_range_r <= (32'(in_cell_x) < MAX_WIDTH) && (32'(in_cell_z) < MAX_LENGTH);
      a_r        <= in_slope_x;
      b_r        <= in_slope_z;
      row_r      <= c_neg;
      t_r        <= c_neg;
      if (in_req_type == REQ_READ) begin
        x_r <= XW'(in_cell_x);
        z_r <= ZW'(in_cell_z);
      end else begin
        x_r <= '0;
        z_r <= '0;
      end
    end else if (cmd.sweep_step) begin
      if (z_end) begin
        z_r   <= '0;
        x_r   <= x_r + XW'(1);
        row_r <= row_inc;
        t_r   <= row_inc;
      end else begin
        z_r <= z_r + ZW'(1);
        t_r <= t_r + TW'(b_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_step) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  assign ram_we = cmd.clear_step || wb_vld_r;
  assign ram_wa = cmd.clear_step ? clr_r : wb_addr_r;
  assign ram_wd = cmd.clear_step ? '0 : h_new;
  assign ram_re = cmd.lookup || cmd.sweep_step;
  assign ram_ra = {x_r, z_r};

  always_ff @(posedge clk) begin
    if (ram_we) begin
      mem[ram_wa] <= ram_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_data_r <= mem[ram_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_vld_r <= 1'b0;
    end else begin
      wb_vld_r <= cmd.sweep_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      wb_addr_r <= ram_ra;
      wb_up_r   <= t_pos;
    end
  end

  assign h_old = rd_data_r;

  always_comb begin
    if (wb_up_r) begin
      h_new = (h_old == HMAX) ? h_old : h_old + HEIGHT_BITS'(1);
    end else begin
      h_new = (h_old == HMIN) ? h_old : h_old - HEIGHT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_high_r <= '0;
      peak_low_r  <= '0;
    end else if (wb_vld_r) begin
      if (wb_up_r && (h_new > peak_high_r)) begin
        peak_high_r <= h_new;
      end
      if (!wb_up_r && (h_new < peak_low_r)) begin
        peak_low_r <= h_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cell_r <= (is_read_r && in_range_r) ? rd_data_r : '0;
      out_hi_r   <= peak_high_r;
      out_lo_r   <= peak_low_r;
    end
  end

  assign cell_ext = EW'(out_cell_r);
  assign hi_ext   = EW'(out_hi_r);
  assign lo_ext   = EW'(out_lo_r);

  assign out_valid       = out_valid_r;
  assign out_cell_height = cell_ext[15:0];
  assign out_max_height  = hi_ext[14:0];
  assign out_min_height  = lo_ext[15:0];

  assign status.clear_last = &clr_r;
  assign status.grid_empty = (gw == '0) || (gl == '0);
  assign status.sweep_last = x_end && z_end;
  assign status.out_free   = !out_valid_r || out_ready;

  `FLH_ASSERT_IMP(a_no_rmw_overlap, clk, rst_n,
    wb_vld_r && cmd.sweep_step, wb_addr_r != ram_ra)
  `FLH_ASSERT_IMP(a_no_result_overwrite, clk, rst_n,
    cmd.load_out, !out_valid_r || out_ready)
  `FLH_ASSERT_IMP(a_peak_signs, clk, rst_n, 1'b1,
    !peak_high_r[HEIGHT_BITS-1] && (peak_low_r[HEIGHT_BITS-1] || (peak_low_r == '0)))

endmodule

>>> hw/rtl/fault_line_heightmap_top.sv
// Fault line heightmap top level. A fault word sweeps the gw*gl grid one cell per cycle
// (memory read-modify-write), then passes a drain state before its result is loaded.
// A read word does a single memory lookup first. One word is worked on at a time.
// After reset a clearing pass zeroes every memory word (MAX_WIDTH and MAX_LENGTH each
// rounded up to a power of two, 65536 words at default) while in_ready stays low.
// Depends on flh_pkg, flh_ctrl and flh_datapath.
module fault_line_heightmap_top #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_LENGTH  = 256,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [flh_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic signed [15:0]          in_slope_x,
  input  logic signed [15:0]          in_slope_z,
  input  logic signed [23:0]          in_line_offset,
  input  logic [flh_pkg::CELL_W-1:0]  in_cell_x,
  input  logic [flh_pkg::CELL_W-1:0]  in_cell_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [15:0]          out_cell_height,
  output logic [14:0]                 out_max_height,
  output logic signed [15:0]          out_min_height
);
  import flh_pkg::*;

  flh_cmd_t    cmd;
  flh_status_t status;

  flh_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .status      (status),
    .cmd         (cmd)
  );

  flh_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_LENGTH  (MAX_LENGTH),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_req_type     (in_req_type),
    .in_slope_x      (in_slope_x),
    .in_slope_z      (in_slope_z),
    .in_line_offset  (in_line_offset),
    .in_cell_x       (in_cell_x),
    .in_cell_z       (in_cell_z),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_cell_height (out_cell_height),
    .out_max_height  (out_max_height),
    .out_min_height  (out_min_height)
  );

endmodule
